/* sv/gbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants of the gshare branch predictor
// Widths of the branch stream, the counter table and the item queue, plus
// the saturating counter helpers used by the back end.
// ----------------------------------------------------------------------------
package gbp_pkg;

  localparam int PC_W        = 24;
  localparam int PC_SHIFT    = 2;
  localparam int IDX_W       = 12;
  localparam int HIST_W      = 12;
  localparam int HLEN_W      = 4;
  localparam int CTR_W       = 3;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  // Effective history length never exceeds the index width or the register.
  localparam int HIST_MAX = (IDX_W < HIST_W) ? IDX_W : HIST_W;

  localparam logic [CTR_W-1:0] CTR_MID = 3'd4;
  localparam logic [CTR_W-1:0] CTR_MAX = 3'd7;
  localparam logic [CTR_W-1:0] CTR_MIN = 3'd0;

  // Item handed from the front end to the back end through the queue.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             taken;
  } item_t;

  function automatic logic [CTR_W-1:0] ctr_update(input logic [CTR_W-1:0] ctr,
                                                  input logic tk);
    logic [CTR_W-1:0] res;
    res = ctr;
    if (tk) begin
      if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
    end
    return res;
  endfunction

endpackage

/* sv/gbp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_front: history register and table index formation
// Holds the history length setting and the global history, hashes each
// accepted branch into a table index and pushes it toward the back end.
// ----------------------------------------------------------------------------
module gbp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gbp_pkg::HLEN_W-1:0]     cfg_wdata,
  input  logic                           accept,
  input  logic [gbp_pkg::PC_W-1:0]       br_addr,
  input  logic                           taken,
  output gbp_pkg::item_t                 item
);

  logic [gbp_pkg::HLEN_W-1:0] history_length;
  logic [gbp_pkg::HIST_W-1:0] history;
  logic [gbp_pkg::HIST_W-1:0] history_next;
  logic [gbp_pkg::HLEN_W-1:0] eff_len;
  logic [gbp_pkg::HIST_W-1:0] hmask;
  logic [gbp_pkg::HIST_W-1:0] hist_low;
  logic [gbp_pkg::HIST_W-1:0] new_bit;
  logic [gbp_pkg::IDX_W-1:0]  pc_idx;
  logic [gbp_pkg::IDX_W-1:0]  hist_idx;

  always_comb begin
    if (history_length > gbp_pkg::HLEN_W'(gbp_pkg::HIST_MAX)) begin
      eff_len = gbp_pkg::HLEN_W'(gbp_pkg::HIST_MAX);
    end else begin
      eff_len = history_length;
    end
    for (int i = 0; i < gbp_pkg::HIST_W; i++) begin
      hmask[i] = (gbp_pkg::HLEN_W'(i) < eff_len);
    end
    hist_low = history & hmask;
    // The newest outcome lands at the top of the active window.
    new_bit  = '0;
    if (eff_len != '0) begin
      new_bit = gbp_pkg::HIST_W'(taken) << (eff_len - gbp_pkg::HLEN_W'(1));
    end
    history_next = (new_bit | (hist_low >> 1)) & hmask;
  end

  assign pc_idx   = br_addr[gbp_pkg::IDX_W+gbp_pkg::PC_SHIFT-1:gbp_pkg::PC_SHIFT];
  assign hist_idx = gbp_pkg::IDX_W'(hist_low);
  assign item.idx   = pc_idx ^ hist_idx;
  assign item.taken = taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_length <= '0;
      history        <= '0;
    end else begin
      if (cfg_we) history_length <= cfg_wdata;
      if (accept && (eff_len != '0)) history <= history_next;
    end
  end

endmodule

/* sv/gbp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_queue: short item queue between front and back ends
// A small register FIFO that lets the front end keep accepting while the
// back end waits on the result side.
// ----------------------------------------------------------------------------
module gbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gbp_pkg::item_t push_item,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output gbp_pkg::item_t head
);

  gbp_pkg::item_t                 entries [gbp_pkg::Q_DEPTH];
  logic [gbp_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [gbp_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [gbp_pkg::Q_CNT_W-1:0]    count;

  assign not_full  = (count != gbp_pkg::Q_CNT_W'(gbp_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + gbp_pkg::Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + gbp_pkg::Q_PTR_W'(1);
      if (push && !pop) begin
        count <= count + gbp_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - gbp_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

/* sv/gbp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_back: counter table read-modify-write and result register
// Clears the counter table after reset, reads one counter per item, forms
// the prediction, writes the updated counter back and holds the result.
// ----------------------------------------------------------------------------
module gbp_back (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        q_valid,
  input  gbp_pkg::item_t              q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_pred,
  output logic                        out_misp,
  output logic [gbp_pkg::IDX_W-1:0]   out_idx
);

  logic [gbp_pkg::CTR_W-1:0] table_mem [gbp_pkg::TABLE_DEPTH];
  logic [gbp_pkg::CTR_W-1:0] mem_q;
  logic [gbp_pkg::IDX_W-1:0] clr_addr;

  gbp_pkg::item_t            s2_item;
  logic                      s2_valid;
  logic                      s2_hit;
  logic [gbp_pkg::CTR_W-1:0] s2_fwd;
  logic [gbp_pkg::CTR_W-1:0] s2_ctr;
  logic [gbp_pkg::CTR_W-1:0] s2_new;
  logic                      s2_adv;
  logic                      s2_pred;

  logic                      wr_en;
  logic [gbp_pkg::IDX_W-1:0] wr_addr;
  logic [gbp_pkg::CTR_W-1:0] wr_data;

  // The read issued as an item enters stage two misses a write landing on
  // the same edge, so that write is captured alongside it.
  assign s2_ctr  = s2_hit ? s2_fwd : mem_q;
  assign s2_pred = (s2_ctr >= gbp_pkg::CTR_MID);
  assign s2_new  = gbp_pkg::ctr_update(s2_ctr, s2_item.taken);
  assign s2_adv  = s2_valid && (!out_valid || out_ready);
  assign q_pop   = q_valid && !clearing && (!s2_valid || s2_adv);

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = gbp_pkg::CTR_MID;
    end else begin
      wr_en   = s2_adv;
      wr_addr = s2_item.idx;
      wr_data = s2_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (q_pop) mem_q <= table_mem[q_head.idx];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_item <= q_head;
      s2_hit  <= s2_adv && (s2_item.idx == q_head.idx);
      s2_fwd  <= s2_new;
    end
    if (s2_adv) begin
      out_pred <= s2_pred;
      out_misp <= s2_pred ^ s2_item.taken;
      out_idx  <= s2_item.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + gbp_pkg::IDX_W'(1);
        if (clr_addr == gbp_pkg::IDX_W'(gbp_pkg::TABLE_DEPTH - 1)) clearing <= 1'b0;
      end
      if (q_pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s2_valid && !q_pop))
    else $error("item in the back end during the table clearing pass");

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> s2_valid)
    else $error("popped item did not reach stage two");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (rst)
    s2_adv |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |=> (s2_valid && $stable(s2_item)))
    else $error("stalled stage two item was lost or changed");

endmodule

/* sv/gshare_branch_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor: gshare predictor with 3-bit saturating counters
//
//   channel  signals                    payload (low bit first)
//   s_       s_tvalid s_tready s_tdata  br_addr[23:0], taken
//   m_       m_tvalid m_tready m_tdata  predicted_taken, mispredict, table_index
//   cfg_     cfg_we cfg_wdata           history_length
//
// One branch per cycle sustained while m_tready stays high; a result is offered
// once its input has passed the queue and the table read, and waits in the result register.
// After reset the 4096-entry counter table is cleared to weakly taken, one
// entry per cycle, so no input is taken until the clearing pass ends.
// A four-entry queue decouples the input side from the table pipeline and
// s_tready drops only when it is full or while the table is being cleared;
// back-to-back updates of one entry are forwarded around the table.
// ----------------------------------------------------------------------------
module gshare_branch_predictor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // br_addr[23:0], taken[24], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // predicted_taken[0], mispredict[1], table_index[13:2]
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  gbp_pkg::item_t             front_item;
  gbp_pkg::item_t             q_head;
  logic                       accept;
  logic                       q_not_full;
  logic                       q_not_empty;
  logic                       q_pop;
  logic                       clearing;
  logic                       out_pred;
  logic                       out_misp;
  logic [gbp_pkg::IDX_W-1:0]  out_idx;

  assign s_tready = q_not_full && !clearing;
  assign accept   = s_tvalid && s_tready;

  gbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .br_addr   (s_tdata[gbp_pkg::PC_W-1:0]),
    .taken     (s_tdata[gbp_pkg::PC_W]),
    .item      (front_item)
  );

  gbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  gbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pred  (out_pred),
    .out_misp  (out_misp),
    .out_idx   (out_idx)
  );

  assign m_tdata = {2'b00, out_idx, out_misp, out_pred};

endmodule
